FILE: rtl/core/gsv_pkg.sv
`default_nettype none

package gsv_pkg;

  // Parser position within the restricted grammar
  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_FIRST       = 4'd1,
    PH_AFTER_Q     = 4'd2,
    PH_OPNAME      = 4'd3,
    PH_AFTER_OP    = 4'd4,
    PH_ROOT        = 4'd5,
    PH_FIELD       = 4'd6,
    PH_AFTER_FIELD = 4'd7,
    PH_COLS        = 4'd8,
    PH_COL         = 4'd9,
    PH_AFTER_COL   = 4'd10,
    PH_DONE        = 4'd11
  } phase_t;

  // Status codes
  localparam logic [3:0] ST_PENDING       = 4'd0;
  localparam logic [3:0] ST_ACCEPTED      = 4'd1;
  localparam logic [3:0] ST_EMPTY_DOC     = 4'd2;
  localparam logic [3:0] ST_NO_OP_BRACE   = 4'd3;
  localparam logic [3:0] ST_MUTATION      = 4'd4;
  localparam logic [3:0] ST_EXPECT_BRACE  = 4'd5;
  localparam logic [3:0] ST_EXPECT_FIELD  = 4'd6;
  localparam logic [3:0] ST_INTROSPECT    = 4'd7;
  localparam logic [3:0] ST_NEED_COLS     = 4'd8;
  localparam logic [3:0] ST_EXPECT_COLUMN = 4'd9;
  localparam logic [3:0] ST_NESTED        = 4'd10;
  localparam logic [3:0] ST_ARGUMENTS     = 4'd11;
  localparam logic [3:0] ST_EMPTY_COLS    = 4'd12;
  localparam logic [3:0] ST_TRAILING      = 4'd13;
  localparam logic [3:0] ST_EMPTY_SEL     = 4'd14;

  // Name event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_FIELD  = 2'd1;
  localparam logic [1:0] EV_COLUMN = 2'd2;

  // Keyword indexes
  localparam int KW_QUERY        = 0;
  localparam int KW_MUTATION     = 1;
  localparam int KW_SUBSCRIPTION = 2;
  localparam int KW_SCHEMA       = 3;
  localparam int KW_TYPE         = 4;
  localparam int KW_NUM          = 5;

  localparam logic [3:0] NAME_LEN_MAX = 4'd15;

  // Keyword text, first character at position 0, zero padded
  localparam logic [0:KW_NUM-1][0:15][7:0] KW_TEXT = {
    {"query",        {11{8'h00}}},
    {"mutation",     {8{8'h00}}},
    {"subscription", {4{8'h00}}},
    {"__schema",     {8{8'h00}}},
    {"__type",       {10{8'h00}}}
  };

  localparam logic [0:KW_NUM-1][3:0] KW_LEN = {4'd5, 4'd8, 4'd12, 4'd8, 4'd6};

  // Character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  function automatic logic is_name_start(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
  endfunction

  function automatic logic is_name_cont(logic [7:0] c);
    return is_name_start(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA};
  endfunction

  // Drop keywords that no longer match after one more name character
  function automatic logic [KW_NUM-1:0] kw_feed(logic [KW_NUM-1:0] hits,
                                                logic [3:0] len, logic [7:0] c);
    logic [KW_NUM-1:0] h;
    h = hits;
    for (int k = 0; k < KW_NUM; k++) begin
      if (!((len < KW_LEN[k]) && (KW_TEXT[k][len] == c))) begin
        h[k] = 1'b0;
      end
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/graphql_subset_validator.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | ch[7:0], end_mark
// out     | output    | out_valid / out_ready| status[3:0], fields_done[7:0],
//         |           |                      | columns_in_field[7:0], name_event[1:0]
//
// One beat in, one beat out. A beat is parsed in the cycle it is accepted and
// its result sits in the output register from the next cycle. Unless stalled,
// throughput is one beat per cycle; the output register is the only stage.
// in_ready drops only while the output register holds a beat that is not taken.
// rst is synchronous, active high, and returns the parser to the start of a document.
`default_nettype none

module graphql_subset_validator
  import gsv_pkg::*;
#(
  parameter int COUNT_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] ch,
  input  wire logic       end_mark,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      status,
  output logic [7:0]      fields_done,
  output logic [7:0]      columns_in_field,
  output logic [1:0]      name_event
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Parser state
  phase_t                  parse_phase, parse_phase_next;
  logic                    in_comment, in_comment_next;
  logic [KW_NUM-1:0]       keyword_hits, keyword_hits_next;
  logic [3:0]              name_length, name_length_next;
  logic [3:0]              latched_error, latched_error_next;
  logic [COUNT_BITS-1:0]   field_counter, field_counter_next;
  logic [COUNT_BITS-1:0]   column_counter, column_counter_next;

  // Step results
  logic [3:0]              step_status;
  logic [1:0]              step_event;
  logic [COUNT_BITS-1:0]   out_fields, out_cols;
  logic [COUNT_BITS+7:0]   out_fields_ext, out_cols_ext;

  // Effect of closing the name being read
  logic                    reading;
  logic [KW_NUM-1:0]       kw_hit;
  phase_t                  ne_phase;
  logic [3:0]              ne_error;
  logic [1:0]              ne_event;
  logic [COUNT_BITS-1:0]   ne_cols;

  // Verdict scratch
  phase_t                  v_phase;
  logic [3:0]              v_error;

  logic                    in_fire;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  assign reading = (parse_phase == PH_FIRST) || (parse_phase == PH_OPNAME) ||
                   (parse_phase == PH_FIELD) || (parse_phase == PH_COL);

  // Close the current name: keyword check, events, column count
  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      kw_hit[k] = keyword_hits[k] && (name_length == KW_LEN[k]);
    end
    ne_phase = parse_phase;
    ne_error = ST_PENDING;
    ne_event = EV_NONE;
    ne_cols  = column_counter;
    case (parse_phase)
      PH_FIRST: begin
        if (kw_hit[KW_QUERY]) begin
          ne_phase = PH_AFTER_Q;
        end else if (kw_hit[KW_MUTATION] || kw_hit[KW_SUBSCRIPTION]) begin
          ne_error = ST_MUTATION;
        end else begin
          ne_error = ST_EXPECT_BRACE;
        end
      end
      PH_OPNAME: ne_phase = PH_AFTER_OP;
      PH_FIELD: begin
        ne_event = EV_FIELD;
        if (kw_hit[KW_SCHEMA] || kw_hit[KW_TYPE]) begin
          ne_error = ST_INTROSPECT;
        end else begin
          ne_phase = PH_AFTER_FIELD;
        end
      end
      PH_COL: begin
        ne_event = EV_COLUMN;
        if (column_counter != CNT_MAX) begin
          ne_cols = column_counter + COUNT_BITS'(1);
        end
        ne_phase = PH_AFTER_COL;
      end
      default: ;
    endcase
  end

  // Parse one beat
  always_comb begin
    parse_phase_next    = parse_phase;
    in_comment_next     = in_comment;
    keyword_hits_next   = keyword_hits;
    name_length_next    = name_length;
    latched_error_next  = latched_error;
    field_counter_next  = field_counter;
    column_counter_next = column_counter;
    step_event          = EV_NONE;
    step_status         = latched_error;
    out_fields          = field_counter;
    out_cols            = column_counter;
    v_phase             = parse_phase;
    v_error             = ST_PENDING;

    if (end_mark) begin
      // Final verdict, then back to the start of a document
      if (latched_error == ST_PENDING) begin
        if (reading) begin
          v_phase    = ne_phase;
          v_error    = ne_error;
          step_event = ne_event;
          out_cols   = ne_cols;
        end
        if (v_error != ST_PENDING) begin
          step_status = v_error;
        end else begin
          case (v_phase)
            PH_START:       step_status = ST_EMPTY_DOC;
            PH_AFTER_Q:     step_status = ST_EXPECT_BRACE;
            PH_AFTER_OP:    step_status = ST_NO_OP_BRACE;
            PH_ROOT:        step_status = ST_EXPECT_FIELD;
            PH_AFTER_FIELD: step_status = ST_NEED_COLS;
            PH_COLS:        step_status = ST_EXPECT_COLUMN;
            PH_AFTER_COL:   step_status = ST_EXPECT_COLUMN;
            default: begin
              step_status = (field_counter == '0) ? ST_EMPTY_SEL : ST_ACCEPTED;
            end
          endcase
        end
      end
      parse_phase_next    = PH_START;
      in_comment_next     = 1'b0;
      keyword_hits_next   = '0;
      name_length_next    = '0;
      latched_error_next  = ST_PENDING;
      field_counter_next  = '0;
      column_counter_next = '0;
    end else if (latched_error == ST_PENDING) begin
      if (reading && is_name_cont(ch)) begin
        // Extend the name
        keyword_hits_next = kw_feed(keyword_hits, name_length, ch);
        if (name_length != NAME_LEN_MAX) begin
          name_length_next = name_length + 4'd1;
        end
      end else begin
        if (reading) begin
          parse_phase_next    = ne_phase;
          latched_error_next  = ne_error;
          step_event          = ne_event;
          column_counter_next = ne_cols;
        end
        if (latched_error_next == ST_PENDING) begin
          if (in_comment) begin
            if (ch == CH_LF) begin
              in_comment_next = 1'b0;
            end
          end else if (is_blank(ch)) begin
            // skip separator
          end else if (ch == CH_HASH) begin
            in_comment_next = 1'b1;
          end else begin
            // Significant character
            case (parse_phase_next)
              PH_START: begin
                if (is_name_start(ch)) begin
                  parse_phase_next  = PH_FIRST;
                  keyword_hits_next = kw_feed('1, 4'd0, ch);
                  name_length_next  = 4'd1;
                end else if (ch == CH_LBRACE) begin
                  parse_phase_next = PH_ROOT;
                end else begin
                  latched_error_next = ST_EXPECT_BRACE;
                end
              end
              PH_AFTER_Q: begin
                if (is_name_start(ch)) begin
                  parse_phase_next  = PH_OPNAME;
                  keyword_hits_next = kw_feed('1, 4'd0, ch);
                  name_length_next  = 4'd1;
                end else if (ch == CH_LBRACE) begin
                  parse_phase_next = PH_ROOT;
                end else begin
                  latched_error_next = ST_EXPECT_BRACE;
                end
              end
              PH_AFTER_OP: begin
                if (ch == CH_LBRACE) begin
                  parse_phase_next = PH_ROOT;
                end else begin
                  latched_error_next = ST_NO_OP_BRACE;
                end
              end
              PH_ROOT: begin
                if (ch == CH_RBRACE) begin
                  parse_phase_next = PH_DONE;
                end else if (is_name_start(ch)) begin
                  parse_phase_next  = PH_FIELD;
                  keyword_hits_next = kw_feed('1, 4'd0, ch);
                  name_length_next  = 4'd1;
                end else begin
                  latched_error_next = ST_EXPECT_FIELD;
                end
              end
              PH_AFTER_FIELD: begin
                if (ch == CH_LBRACE) begin
                  column_counter_next = '0;
                  parse_phase_next    = PH_COLS;
                end else begin
                  latched_error_next = ST_NEED_COLS;
                end
              end
              PH_COLS, PH_AFTER_COL: begin
                if ((parse_phase_next == PH_AFTER_COL) && (ch == CH_LBRACE)) begin
                  latched_error_next = ST_NESTED;
                end else if ((parse_phase_next == PH_AFTER_COL) && (ch == CH_LPAREN)) begin
                  latched_error_next = ST_ARGUMENTS;
                end else if (ch == CH_RBRACE) begin
                  // Close the field
                  if (column_counter_next == '0) begin
                    latched_error_next = ST_EMPTY_COLS;
                  end else begin
                    if (field_counter != CNT_MAX) begin
                      field_counter_next = field_counter + COUNT_BITS'(1);
                    end
                    parse_phase_next = PH_ROOT;
                  end
                end else if (is_name_start(ch)) begin
                  parse_phase_next  = PH_COL;
                  keyword_hits_next = kw_feed('1, 4'd0, ch);
                  name_length_next  = 4'd1;
                end else begin
                  latched_error_next = ST_EXPECT_COLUMN;
                end
              end
              default: latched_error_next = ST_TRAILING;
            endcase
          end
        end
      end
      step_status = latched_error_next;
      out_fields  = field_counter_next;
      out_cols    = column_counter_next;
    end
  end

  assign out_fields_ext = {8'd0, out_fields};
  assign out_cols_ext   = {8'd0, out_cols};

  // Parser state, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_START;
      in_comment     <= 1'b0;
      keyword_hits   <= '0;
      name_length    <= '0;
      latched_error  <= ST_PENDING;
      field_counter  <= '0;
      column_counter <= '0;
    end else if (in_fire) begin
      parse_phase    <= parse_phase_next;
      in_comment     <= in_comment_next;
      keyword_hits   <= keyword_hits_next;
      name_length    <= name_length_next;
      latched_error  <= latched_error_next;
      field_counter  <= field_counter_next;
      column_counter <= column_counter_next;
    end
  end

  // Output register valid: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status           <= step_status;
      fields_done      <= out_fields_ext[7:0];
      columns_in_field <= out_cols_ext[7:0];
      name_event       <= step_event;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gsv_checker.sv
`default_nettype none

module gsv_checker
  import gsv_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] ch,
  input wire logic       end_mark,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] status,
  input wire logic [7:0] fields_done,
  input wire logic [7:0] columns_in_field,
  input wire logic [1:0] name_event
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(fields_done) && $stable(columns_in_field) && $stable(name_event))
    else $error("stalled result beat changed");

  // Hold a stalled input beat
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(ch) && $stable(end_mark))
    else $error("stalled input beat changed");

  // An empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Every accepted beat shows up in the output register next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // A column name ends while pending, at a missing column, or at a nested or argument error
  a_column_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && (name_event == EV_COLUMN) |->
      (status == ST_PENDING) || (status == ST_EXPECT_COLUMN) ||
      (status == ST_NESTED) || (status == ST_ARGUMENTS))
    else $error("column event with unexpected status");

endmodule

bind graphql_subset_validator gsv_checker u_gsv_checker (.*);

`default_nettype wire
